FILE: rtl/b64se_pkg.sv
// Shared types, constants and the character mapping for the Base64 stream encoder.
`timescale 1ns / 1ps

package b64se_pkg;

  // Queue between front and back; depth must be a power of two.
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam int CharW      = 7;
  localparam int GroupChars = 4;

  localparam logic [CharW-1:0] PadChar   = 7'h3D;  // '='
  localparam logic [CharW-1:0] PlusChar  = 7'h2B;  // '+'
  localparam logic [CharW-1:0] SlashChar = 7'h2F;  // '/'

  // One classified input byte: the characters it produces and where they stop.
  typedef struct packed {
    logic [GroupChars-1:0][CharW-1:0] chars;
    logic [1:0]                       last_idx;
    logic                             eom;
  } item_t;

  // Map a 6-bit value onto the standard Base64 alphabet.
  function automatic logic [CharW-1:0] sym(input logic [5:0] v);
    logic [CharW-1:0] wide;
    wide = {1'b0, v};
    if (v < 6'd26) begin
      sym = wide + 7'd65;   // 'A'..'Z'
    end else if (v < 6'd52) begin
      sym = wide + 7'd71;   // 'a'..'z'
    end else if (v < 6'd62) begin
      sym = wide - 7'd4;    // '0'..'9'
    end else if (v == 6'd62) begin
      sym = PlusChar;
    end else begin
      sym = SlashChar;
    end
  endfunction

endpackage

FILE: rtl/b64se_front.sv
// Front end: accepts bytes, tracks the group position and builds character groups.
`timescale 1ns / 1ps

module b64se_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 end_of_message_i,
  input  logic                 queue_full_i,
  output logic                 push_o,
  output b64se_pkg::item_t     item_o
);

  typedef enum logic [1:0] {
    PosFirst  = 2'd0,
    PosSecond = 2'd1,
    PosThird  = 2'd2
  } pos_e;

  pos_e       pos_q, pos_d;
  logic [3:0] carry_q, carry_d;

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    item_o     = '0;
    item_o.eom = end_of_message_i;
    pos_d      = PosFirst;
    carry_d    = '0;
    unique case (pos_q)
      PosSecond: begin
        item_o.chars[0] = b64se_pkg::sym({carry_q[1:0], data_byte_i[7:4]});
        item_o.chars[1] = b64se_pkg::sym({data_byte_i[3:0], 2'b00});
        item_o.chars[2] = b64se_pkg::PadChar;
        item_o.chars[3] = b64se_pkg::PadChar;
        item_o.last_idx = end_of_message_i ? 2'd2 : 2'd0;
        if (!end_of_message_i) begin
          pos_d   = PosThird;
          carry_d = data_byte_i[3:0];
        end
      end
      PosThird: begin
        item_o.chars[0] = b64se_pkg::sym({carry_q, data_byte_i[7:6]});
        item_o.chars[1] = b64se_pkg::sym(data_byte_i[5:0]);
        item_o.chars[2] = b64se_pkg::PadChar;
        item_o.chars[3] = b64se_pkg::PadChar;
        item_o.last_idx = 2'd1;
      end
      default: begin
        item_o.chars[0] = b64se_pkg::sym(data_byte_i[7:2]);
        item_o.chars[1] = b64se_pkg::sym({data_byte_i[1:0], 4'b0000});
        item_o.chars[2] = b64se_pkg::PadChar;
        item_o.chars[3] = b64se_pkg::PadChar;
        item_o.last_idx = end_of_message_i ? 2'd3 : 2'd0;
        if (!end_of_message_i) begin
          pos_d   = PosSecond;
          carry_d = {2'b00, data_byte_i[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosFirst;
      carry_q <= '0;
    end else if (push_o) begin
      pos_q   <= pos_d;
      carry_q <= carry_d;
    end
  end

endmodule

FILE: rtl/b64se_queue.sv
// Short FIFO of character groups between the front and back ends.
`timescale 1ns / 1ps

module b64se_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64se_pkg::item_t    item_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output b64se_pkg::item_t    head_o
);

  b64se_pkg::item_t                    mem_q [b64se_pkg::QueueDepth];
  logic [b64se_pkg::QueuePtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [b64se_pkg::QueueCntW-1:0]     count_q, count_d;

  assign full_o  = (count_q == b64se_pkg::QueueCntW'(b64se_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

FILE: rtl/b64se_back.sv
// Back end: walks each queued group one character at a time into the output register.
`timescale 1ns / 1ps

module b64se_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  b64se_pkg::item_t              head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [b64se_pkg::CharW-1:0]   out_char_o,
  output logic                          last_char_o
);

  logic                          valid_q, valid_d;
  logic [b64se_pkg::CharW-1:0]   char_q, char_d;
  logic                          last_q, last_d;
  logic [1:0]                    idx_q, idx_d;
  logic                          load;
  logic                          at_end;

  assign load   = head_valid_i && (!valid_q || !out_stall_i);
  assign at_end = (idx_q == head_i.last_idx);
  assign pop_o  = load && at_end;

  always_comb begin
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      char_d  = head_i.chars[idx_q];
      last_d  = head_i.eom && at_end;
      idx_d   = at_end ? 2'd0 : idx_q + 2'd1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign last_char_o = last_q;

endmodule

FILE: rtl/base64_stream_encoder.sv
// Top level of the Base64 stream encoder: front end, group queue and character back end.
// A byte's first character is written into the group queue and from there into the output register.
// Throughput: one character per cycle on the output while a group is queued and
// out_stall_i is low; the single-character output register sets that rate.
// A byte is taken every cycle while the two-entry group queue has room.
// Reset (rst_ni low, asynchronous) empties the queue and output and restarts a group.
`timescale 1ns / 1ps

module base64_stream_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_message_i,
  // Character output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  out_char_o,
  output logic        last_char_o
);

  // Front to queue: one group of up to four characters per accepted item.
  logic             push;
  b64se_pkg::item_t push_item;

  // Queue to back: head group and its handshake.
  logic             pop;
  logic             full;
  logic             empty;
  b64se_pkg::item_t head_item;

  // Classify the byte against the group position and build its characters.
  b64se_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .queue_full_i     (full),
    .push_o           (push),
    .item_o           (push_item)
  );

  // Hold groups so input keeps flowing while the output drains or stalls.
  b64se_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head_item)
  );

  // Emit the head group one character per unstalled cycle; drop it after its last one.
  b64se_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!empty),
    .head_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .last_char_o  (last_char_o)
  );

  // The queue never takes a group while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && full))
    else $error("group pushed into full queue");

  // The back end never drops a group that is not there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop && empty))
    else $error("group popped from empty queue");

  // An output character is only produced from a queued group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!out_valid_o && empty) |=> !out_valid_o)
    else $error("output valid without a queued group");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the Base64 stream encoder: directed bytes, random messages.
`timescale 1ns / 1ps

module tb;

  // One encoded character as it leaves the block.
  typedef struct packed {
    logic [b64se_pkg::CharW-1:0] ch;
    logic                        last;
  } b64_char_t;

  // One directed byte; text holds the typed-in characters, zero means "ask the encoder model".
  typedef struct packed {
    logic [7:0]  data;
    logic        eom;
    logic [31:0] text;
  } byte_row_t;

  localparam int NumRows    = 23;
  localparam int QuietLimit = 1000;  // cycles with no item moving on either channel
  localparam int HoldCycles = 60;    // long receiver hold-off to fill the group queue

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [7:0]                  data_byte_i;
  logic                        end_of_message_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [b64se_pkg::CharW-1:0] out_char_o;
  logic                        last_char_o;

  // Characters still owed by the block, oldest first.
  b64_char_t expected_chars[$];

  // Encoder model state: byte index within the 3-byte group and the leftover low bits.
  logic [1:0] grp_pos;
  logic [3:0] carry;

  string     alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  int        mismatches   = 0;
  int        idle_pct     = 0;
  int        stall_pct    = 0;
  int        hold_left    = 0;
  int        quiet_cycles = 0;
  byte_row_t rows [NumRows];

  base64_stream_encoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_char_o       (out_char_o),
    .last_char_o      (last_char_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Map a 6-bit value onto its alphabet character.
  function automatic logic [b64se_pkg::CharW-1:0] b64(input logic [5:0] v);
    byte c;
    c = alphabet[v];
    return c[b64se_pkg::CharW-1:0];
  endfunction

  // Append one owed character when keep is set.
  task automatic owe_char(input logic [b64se_pkg::CharW-1:0] ch, input logic last,
                          input bit keep);
    b64_char_t c;
    c.ch   = ch;
    c.last = last;
    if (keep) begin
      expected_chars = {expected_chars, c};
    end
  endtask

  // Advance the encoder model by one byte; queue its characters when keep is set.
  task automatic encode_byte(input logic [7:0] b, input logic eom, input bit keep);
    case (grp_pos)
      2'd1: begin
        owe_char(b64({carry[1:0], b[7:4]}), 1'b0, keep);
        if (eom) begin
          owe_char(b64({b[3:0], 2'b00}), 1'b0, keep);
          owe_char(b64se_pkg::PadChar, 1'b1, keep);
          grp_pos = 2'd0;
          carry   = 4'd0;
        end else begin
          grp_pos = 2'd2;
          carry   = b[3:0];
        end
      end
      2'd2: begin
        // Third byte closes the group whatever the flag says.
        owe_char(b64({carry, b[7:6]}), 1'b0, keep);
        owe_char(b64(b[5:0]), eom, keep);
        grp_pos = 2'd0;
        carry   = 4'd0;
      end
      default: begin
        owe_char(b64(b[7:2]), 1'b0, keep);
        if (eom) begin
          owe_char(b64({b[1:0], 4'b0000}), 1'b0, keep);
          owe_char(b64se_pkg::PadChar, 1'b0, keep);
          owe_char(b64se_pkg::PadChar, 1'b1, keep);
          grp_pos = 2'd0;
          carry   = 4'd0;
        end else begin
          grp_pos = 2'd1;
          carry   = {2'b00, b[1:0]};
        end
      end
    endcase
  endtask

  // Queue typed-in characters; the rightmost one carries the message-end flag.
  task automatic push_typed(input logic [31:0] text, input logic eom);
    for (int k = 3; k >= 0; k--) begin
      if (text[8*k +: 8] != 8'h00) begin
        owe_char(text[8*k +: b64se_pkg::CharW], eom && (k == 0), 1'b1);
      end
    end
  endtask

  // Offer one byte, hold it until taken, then log what it must produce.
  task automatic send_byte(input logic [7:0] b, input logic eom, input logic [31:0] text);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    data_byte_i      <= b;
    end_of_message_i <= eom;
    do @(posedge clk_i); while (in_stall_o);
    encode_byte(b, eom, text == 32'd0);
    if (text != 32'd0) push_typed(text, eom);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1, 32'd0);
    end
  endtask

  // Send whole messages, mostly short, now and then long, until the item count is met.
  task automatic run_phase(input int idle, input int stall, input int items);
    int sent;
    int len;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 10) : $urandom_range(6, 1);
      send_message(len);
      sent += len;
    end
  endtask

  // Receiver: check each taken character, then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    b64_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last %0b", out_char_o, last_char_o));
      end else begin
        want = expected_chars.pop_front();
        if (out_char_o !== want.ch) begin
          report_mismatch($sformatf("char 0x%02h, want 0x%02h", out_char_o, want.ch));
        end
        if (last_char_o !== want.last) begin
          report_mismatch($sformatf("last_char %0b, want %0b", last_char_o, want.last));
        end
      end
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    data_byte_i      = 8'h00;
    end_of_message_i = 1'b0;
    out_stall_i      = 1'b0;
    grp_pos          = 2'd0;
    carry            = 4'd0;

    // Directed bytes: single-byte messages at both extremes, a full group,
    // two-byte messages, 00 at every group position and FF at the first two.
    rows = '{
      '{8'h00, 1'b1, "AA=="},
      '{8'hFF, 1'b1, "/w=="},
      '{8'h4D, 1'b0, "T"},
      '{8'h61, 1'b0, "W"},
      '{8'h6E, 1'b1, "Fu"},
      '{8'hFF, 1'b0, "/"},
      '{8'hFF, 1'b1, "/8="},
      '{8'hFB, 1'b0, "+"},
      '{8'hEF, 1'b0, 32'd0},
      '{8'hBE, 1'b0, 32'd0},
      '{8'h00, 1'b0, "A"},
      '{8'h00, 1'b0, 32'd0},
      '{8'h00, 1'b1, "AA"},
      '{8'h80, 1'b0, 32'd0},
      '{8'h01, 1'b1, 32'd0},
      '{8'h7F, 1'b0, 32'd0},
      '{8'hC3, 1'b0, 32'd0},
      '{8'h3C, 1'b0, 32'd0},
      '{8'h55, 1'b0, 32'd0},
      '{8'hAA, 1'b1, 32'd0},
      '{8'h0F, 1'b1, 32'd0},
      '{8'hF0, 1'b0, 32'd0},
      '{8'h5A, 1'b1, 32'd0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_byte(rows[i].data, rows[i].eom, rows[i].text);

    run_phase(0, 0, 40);
    run_phase(54, 0, 50);
    run_phase(0, 54, 50);
    run_phase(11, 11, 50);
    // Hold the output off while bytes keep coming, so the queue fills and stalls input.
    hold_left = HoldCycles;
    run_phase(0, 0, 40);

    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/b64se_pkg.sv
rtl/b64se_front.sv
rtl/b64se_queue.sv
rtl/b64se_back.sv
rtl/base64_stream_encoder.sv
sim/tb.sv
